FILE: sv/isle_pkg.sv
`default_nettype none

package isle_pkg;

   // Sizing of the element row.
   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Fixed widths of the request and response fields.
   localparam int KIND_W   = 4;
   localparam int POS_W    = 16;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT   = 4'd0,
      KIND_PUSH_BACK    = 4'd1,
      KIND_INSERT_AT    = 4'd2,
      KIND_POP_FRONT    = 4'd3,
      KIND_POP_BACK     = 4'd4,
      KIND_REMOVE_AT    = 4'd5,
      KIND_REMOVE_VALUE = 4'd6,
      KIND_READ_FRONT   = 4'd7,
      KIND_READ_BACK    = 4'd8,
      KIND_READ_AT      = 4'd9
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef logic [DATA_WIDTH-1:0] elem_type;

   // Per-cell command: load the new word, or take a neighbour's word.
   typedef struct packed {
      logic load;
      logic take_left;
      logic take_right;
   } cell_cmd_type;

   // A request word is stored as its low bits after sign extension.
   function automatic elem_type to_elem(input logic [WORD_W-1:0] w);
      logic signed [WORD_W-1:0] s;
      s = w;
      return DATA_WIDTH'(s);
   endfunction

   // A stored element is read back sign extended and cut to a word.
   function automatic logic [WORD_W-1:0] to_word(input elem_type e);
      logic signed [DATA_WIDTH-1:0] s;
      s = e;
      return WORD_W'(s);
   endfunction

endpackage

`default_nettype wire

FILE: sv/indexed_sequence_list_engine.sv
// The response word is strobed on rsp_valid from the response registers, loaded in the execute state.
// A request is accepted only while idle; busy is high for the single execute cycle in
// which every cell of the row shifts, loads or holds in parallel from the registered request.
// Reset clears the element count and the sequencer; the element cells are not cleared.
// The receiver cannot stall: each response is strobed on rsp_valid for exactly one cycle.
`default_nettype none

module indexed_sequence_list_engine (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [isle_pkg::KIND_W-1:0]         req_kind,
   input  wire logic signed [isle_pkg::POS_W-1:0]   req_position,
   input  wire logic signed [isle_pkg::WORD_W-1:0]  req_data_value,
   output logic                                     rsp_valid,
   output logic signed [isle_pkg::WORD_W-1:0]       rsp_read_value,
   output logic [isle_pkg::COUNT_W-1:0]             rsp_element_count,
   output logic [isle_pkg::STATUS_W-1:0]            rsp_status
);
   import isle_pkg::*;

   elem_type            cell_values [CAPACITY];
   elem_type            left_values [CAPACITY];
   elem_type            right_values [CAPACITY];
   cell_cmd_type        cell_cmds [CAPACITY];
   logic [CAPACITY-1:0] cell_match;
   elem_type            key;

   // Sequencer: request register, count, row commands and response word.
   isle_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_position      (req_position),
      .req_data_value    (req_data_value),
      .cell_values       (cell_values),
      .cell_match        (cell_match),
      .key               (key),
      .cell_cmds         (cell_cmds),
      .rsp_valid         (rsp_valid),
      .rsp_read_value    (rsp_read_value),
      .rsp_element_count (rsp_element_count),
      .rsp_status        (rsp_status)
   );

   // Row of cells; the ends see their own word as the missing neighbour.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_values[i] = cell_values[i];
      end else begin : g_inner_left
         assign left_values[i] = cell_values[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_values[i] = cell_values[i];
      end else begin : g_inner_right
         assign right_values[i] = cell_values[i+1];
      end

      isle_cell u_cell (
         .clock       (clock),
         .cmd         (cell_cmds[i]),
         .left_value  (left_values[i]),
         .right_value (right_values[i]),
         .key         (key),
         .value       (cell_values[i]),
         .match       (cell_match[i])
      );
   end

   // An accepted request keeps the block busy for the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted request did not enter execution");

   // Every execute cycle is followed by exactly one response strobe.
   assert property (@(posedge clock) disable iff (reset) busy |=> (rsp_valid && !busy))
      else $error("execute cycle not followed by a response");

   // A response is never strobed while a request executes.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("response strobe overlaps execution");

   // A dropped insert reports a full list.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |->
         (rsp_element_count == COUNT_W'(CAPACITY)))
      else $error("full status with a list that is not full");

endmodule

`default_nettype wire

FILE: sv/isle_cell.sv
`default_nettype none

module isle_cell (
   input  wire logic                   clock,
   input  isle_pkg::cell_cmd_type      cmd,
   input  isle_pkg::elem_type          left_value,
   input  isle_pkg::elem_type          right_value,
   input  isle_pkg::elem_type          key,
   output isle_pkg::elem_type          value,
   output logic                        match
);
   import isle_pkg::*;

   elem_type value_ff;
   elem_type value_in;

   // Pick the next word: the new word, a neighbour's word, or our own.
   always_comb begin
      priority if (cmd.load) begin
         value_in = key;
      end else if (cmd.take_left) begin
         value_in = left_value;
      end else if (cmd.take_right) begin
         value_in = right_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // The word is offered to both neighbours and compared with the key.
   assign value = value_ff;
   assign match = (value_ff == key);

endmodule

`default_nettype wire

FILE: sv/isle_seq.sv
`default_nettype none

module isle_seq (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [isle_pkg::KIND_W-1:0]         req_kind,
   input  wire logic signed [isle_pkg::POS_W-1:0]   req_position,
   input  wire logic signed [isle_pkg::WORD_W-1:0]  req_data_value,
   input  isle_pkg::elem_type                       cell_values [isle_pkg::CAPACITY],
   input  wire logic [isle_pkg::CAPACITY-1:0]       cell_match,
   output isle_pkg::elem_type                       key,
   output isle_pkg::cell_cmd_type                   cell_cmds [isle_pkg::CAPACITY],
   output logic                                     rsp_valid,
   output logic signed [isle_pkg::WORD_W-1:0]       rsp_read_value,
   output logic [isle_pkg::COUNT_W-1:0]             rsp_element_count,
   output logic [isle_pkg::STATUS_W-1:0]            rsp_status
);
   import isle_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [KIND_W-1:0]       kind_ff;
   logic [POS_W-1:0]        pos_ff;
   elem_type                key_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff;
   logic [WORD_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]      rsp_count_ff;
   status_type              rsp_status_ff, status_in;

   logic                    accept;
   logic                    exec;
   logic                    empty, full;
   logic                    pos_nonpos, pos_ge;
   logic [POS_W-2:0]        pos_mag;
   logic [IDX_W-1:0]        last_idx, clamp_idx, ins_idx, rm_idx, rd_idx;
   logic                    do_insert, do_remove_pos, do_remove_val, do_read;
   logic [CAPACITY-1:0]     valid_mask, match_valid;
   logic [CAPACITY-1:0]     pfx [IDX_W+1];
   logic                    any_match;

   assign accept = start && (state_ff == ST_IDLE);
   assign exec   = (state_ff == ST_EXEC);
   assign busy   = exec;
   assign key    = key_ff;

   // Two-state sequencer: take a request, then execute it across the row.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         pos_ff  <= req_position;
         key_ff  <= to_elem(req_data_value);
      end
   end

   // Position decoding: negative or zero means front, at or past count means back.
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign pos_mag    = pos_ff[POS_W-2:0];
   assign pos_nonpos = pos_ff[POS_W-1] || (pos_mag == '0);
   assign pos_ge     = !pos_ff[POS_W-1] && (pos_mag >= (POS_W-1)'(count_ff));
   assign last_idx   = IDX_W'(count_ff - 1'b1);
   assign clamp_idx  = pos_nonpos ? '0 : (pos_ge ? last_idx : IDX_W'(pos_mag));

   // Valid cells and the first valid match, found by a prefix OR.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid_mask[i] = (CNT_W'(i) < count_ff);
      end
      match_valid = cell_match & valid_mask;
      pfx[0] = match_valid;
      for (int l = 0; l < IDX_W; l++) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (i >= (1 << l)) begin
               pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
            end else begin
               pfx[l+1][i] = pfx[l][i];
            end
         end
      end
   end

   assign any_match = |match_valid;

   // Decode the request into an operation, its cell index and its status.
   always_comb begin
      do_insert     = 1'b0;
      do_remove_pos = 1'b0;
      do_remove_val = 1'b0;
      do_read       = 1'b0;
      ins_idx       = '0;
      rm_idx        = '0;
      rd_idx        = '0;
      status_in     = STATUS_DONE;
      count_in      = count_ff;
      unique case (kind_ff)
         KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT_AT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               do_insert = 1'b1;
               count_in  = count_ff + 1'b1;
               if (kind_ff == KIND_PUSH_FRONT) begin
                  ins_idx = '0;
               end else if (kind_ff == KIND_PUSH_BACK || pos_ge) begin
                  ins_idx = IDX_W'(count_ff);
               end else if (pos_nonpos) begin
                  ins_idx = '0;
               end else begin
                  ins_idx = IDX_W'(pos_mag);
               end
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK, KIND_REMOVE_AT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               do_remove_pos = 1'b1;
               count_in      = count_ff - 1'b1;
               if (kind_ff == KIND_POP_FRONT) begin
                  rm_idx = '0;
               end else if (kind_ff == KIND_POP_BACK) begin
                  rm_idx = last_idx;
               end else begin
                  rm_idx = clamp_idx;
               end
            end
         end
         KIND_REMOVE_VALUE: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else if (!any_match) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               do_remove_val = 1'b1;
               count_in      = count_ff - 1'b1;
            end
         end
         KIND_READ_FRONT, KIND_READ_BACK, KIND_READ_AT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               do_read = 1'b1;
               if (kind_ff == KIND_READ_FRONT) begin
                  rd_idx = '0;
               end else if (kind_ff == KIND_READ_BACK) begin
                  rd_idx = last_idx;
               end else begin
                  rd_idx = clamp_idx;
               end
            end
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
   end

   // Commands to the row: shift towards the back on insert, towards the front on removal.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_cmds[i].load       = exec && do_insert && (IDX_W'(i) == ins_idx);
         cell_cmds[i].take_left  = exec && do_insert && (IDX_W'(i) > ins_idx);
         cell_cmds[i].take_right = exec && (i < CAPACITY - 1) &&
                                   ((do_remove_pos && (IDX_W'(i) >= rm_idx)) ||
                                    (do_remove_val && pfx[IDX_W][i]));
      end
   end

   // Read word for read requests, zero otherwise.
   assign rsp_value_in = do_read ? to_word(cell_values[rd_idx]) : '0;

   // Element count and response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= exec;
         if (exec) begin
            count_ff <= count_in;
         end
      end
   end

   // Response word register.
   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= COUNT_W'(count_in);
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire
